>>> hw/rtl/kdmc_pkg.sv
// kdmc_pkg: types, key codes and constants shared by the keypad motor command unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package kdmc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_BOOST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_STEP    = 2'd2;

  localparam logic [6:0] TURN_BOOST_RST    = 7'd25;
  localparam logic [6:0] OBSTACLE_DUTY_RST = 7'd30;
  localparam logic [6:0] BRAKE_STEP_RST    = 7'd10;

  // keypad directions
  localparam logic [3:0] DIR_BACK_LEFT  = 4'd1;
  localparam logic [3:0] DIR_BACK       = 4'd2;
  localparam logic [3:0] DIR_BACK_RIGHT = 4'd3;
  localparam logic [3:0] DIR_LEFT       = 4'd4;
  localparam logic [3:0] DIR_STOP       = 4'd5;
  localparam logic [3:0] DIR_RIGHT      = 4'd6;
  localparam logic [3:0] DIR_FWD_LEFT   = 4'd7;
  localparam logic [3:0] DIR_FWD        = 4'd8;
  localparam logic [3:0] DIR_FWD_RIGHT  = 4'd9;

  // ascii key codes
  localparam logic [7:0] KEY_ONE   = 8'h31;
  localparam logic [7:0] KEY_THREE = 8'h33;
  localparam logic [7:0] KEY_NINE  = 8'h39;
  localparam logic [7:0] KEY_BRAKE = 8'h42;
  localparam logic [7:0] KEY_A     = 8'h61;
  localparam logic [7:0] KEY_S     = 8'h73;
  localparam logic [7:0] KEY_D     = 8'h64;
  localparam logic [7:0] KEY_F     = 8'h66;
  localparam logic [7:0] KEY_G     = 8'h67;
  localparam logic [7:0] KEY_H     = 8'h68;
  localparam logic [7:0] KEY_J     = 8'h6a;
  localparam logic [7:0] KEY_K     = 8'h6b;
  localparam logic [7:0] KEY_L     = 8'h6c;
  localparam logic [7:0] KEY_SEMI  = 8'h3b;

  localparam logic [6:0] DUTY_MAX     = 7'd100;
  localparam logic [7:0] BOOST_CAP    = 8'd200;
  localparam logic [7:0] INNER_OFFSET = 8'd5;
  // x/3 == (x*171)>>9 for every x below 256
  localparam logic [15:0] DIV3_MUL    = 16'd171;
  localparam int unsigned DIV3_SHIFT  = 9;

  typedef struct packed {
    logic [3:0] dir;
    logic [6:0] duty;
    logic [6:0] base;
  } kdmc_state_t;

  typedef struct packed {
    logic       run;
    logic       fwd;
    logic [7:0] duty;
  } kdmc_chan_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] level;
  } kdmc_base_t;

  localparam kdmc_state_t STATE_RST = '{dir: DIR_STOP, duty: 7'd0, base: 7'd0};

  // letter row sets the base duty in steps of ten
  function automatic kdmc_base_t base_lookup(input logic [7:0] key);
    kdmc_base_t r;
    r.hit   = 1'b1;
    r.level = 7'd0;
    case (key)
      KEY_A:    r.level = 7'd10;
      KEY_S:    r.level = 7'd20;
      KEY_D:    r.level = 7'd30;
      KEY_F:    r.level = 7'd40;
      KEY_G:    r.level = 7'd50;
      KEY_H:    r.level = 7'd60;
      KEY_J:    r.level = 7'd70;
      KEY_K:    r.level = 7'd80;
      KEY_L:    r.level = 7'd90;
      KEY_SEMI: r.level = DUTY_MAX;
      default:  r.hit   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/keypad_differential_motor_command_unit.sv
// Keypad differential motor command unit. Each accepted item (a key code with
// unlock and obstacle flags) updates the stored direction, running duty and
// base duty and yields one result with both wheel channels and the new state.
// One item per clock is sustained while out_stall is low; each item passes
// the input register, then the result register. While the result register
// is stalled one more item is taken into the input register, after which
// in_stall rises. Configuration writes are always ready and take effect at
// once; write them only while no item is in flight. Out-of-range indexes
// are ignored.
// depends on kdmc_pkg, kdmc_key_decode, kdmc_channel_map
`timescale 1ns / 1ps
`default_nettype none

module keypad_differential_motor_command_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_key,
  input  wire logic                               in_unlocked,
  input  wire logic                               in_obstacle,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_left_run,
  output logic                                    out_left_forward,
  output logic [7:0]                              out_left_duty,
  output logic                                    out_right_run,
  output logic                                    out_right_forward,
  output logic [7:0]                              out_right_duty,
  output logic                                    out_override_active,
  output logic [3:0]                              out_direction_now,
  output logic [6:0]                              out_duty_now,
  output logic [6:0]                              out_base_now,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [kdmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [6:0]                         cfg_data
);
  import kdmc_pkg::*;

  logic [6:0]  tb_r;
  logic [6:0]  obs_duty_r;
  logic [6:0]  brake_step_r;

  kdmc_state_t state_r;
  kdmc_state_t state_nxt;

  logic        in_valid_r;
  logic [7:0]  key_r;
  logic        unl_r;
  logic        obs_r;

  logic        out_valid_r;
  kdmc_chan_t  left_r;
  kdmc_chan_t  right_r;
  logic        ovr_r;
  kdmc_state_t snap_r;

  logic        map_en;
  logic        ovr;
  kdmc_chan_t  chan_left;
  kdmc_chan_t  chan_right;
  logic        advance;
  logic        in_take;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  kdmc_key_decode u_decode (
    .key           (key_r),
    .unlocked      (unl_r),
    .obstacle      (obs_r),
    .obstacle_duty (obs_duty_r),
    .brake_step    (brake_step_r),
    .state         (state_r),
    .state_nxt     (state_nxt),
    .map_en        (map_en),
    .ovr           (ovr)
  );

  kdmc_channel_map u_map (
    .state      (state_nxt),
    .map_en     (map_en),
    .turn_boost (tb_r),
    .chan_left  (chan_left),
    .chan_right (chan_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tb_r         <= TURN_BOOST_RST;
      obs_duty_r   <= OBSTACLE_DUTY_RST;
      brake_step_r <= BRAKE_STEP_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TURN_BOOST:    tb_r         <= cfg_data;
          REG_OBSTACLE_DUTY: obs_duty_r   <= cfg_data;
          REG_BRAKE_STEP:    brake_step_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      key_r <= in_key;
      unl_r <= in_unlocked;
      obs_r <= in_obstacle;
    end
    if (advance) begin
      left_r  <= chan_left;
      right_r <= chan_right;
      ovr_r   <= ovr;
      snap_r  <= state_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_run        = left_r.run;
  assign out_left_forward    = left_r.fwd;
  assign out_left_duty       = left_r.duty;
  assign out_right_run       = right_r.run;
  assign out_right_forward   = right_r.fwd;
  assign out_right_duty      = right_r.duty;
  assign out_override_active = ovr_r;
  assign out_direction_now   = snap_r.dir;
  assign out_duty_now        = snap_r.duty;
  assign out_base_now        = snap_r.base;

endmodule

`default_nettype wire

>>> hw/rtl/kdmc_key_decode.sv
// kdmc_key_decode: next state from the key, the override flags and the current state
// depends on kdmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module kdmc_key_decode (
  input  wire logic [7:0]          key,
  input  wire logic                unlocked,
  input  wire logic                obstacle,
  input  wire logic [6:0]          obstacle_duty,
  input  wire logic [6:0]          brake_step,
  input  wire kdmc_pkg::kdmc_state_t state,
  output kdmc_pkg::kdmc_state_t    state_nxt,
  output logic                     map_en,
  output logic                     ovr
);
  import kdmc_pkg::*;

  logic       is_digit;
  logic       is_obs_digit;
  kdmc_base_t base_hit;

  always_comb begin
    is_digit     = (key >= KEY_ONE) && (key <= KEY_NINE);
    is_obs_digit = (key >= KEY_ONE) && (key <= KEY_THREE);
    base_hit     = base_lookup(key);
    ovr          = unlocked & obstacle;
    state_nxt    = state;

    if (is_digit) begin
      state_nxt.dir  = key[3:0];
      state_nxt.duty = state.base;
    end else if (base_hit.hit) begin
      state_nxt.base = base_hit.level;
    end else if (key == KEY_BRAKE) begin
      state_nxt.duty = (state.duty >= brake_step) ? state.duty - brake_step : 7'd0;
    end

    // with unlocked and obstacle both set, reverse moves take the obstacle duty, everything else stops
    if (ovr && is_obs_digit) begin
      state_nxt.dir  = key[3:0];
      state_nxt.duty = obstacle_duty;
    end
    map_en = !ovr || is_obs_digit;
  end

endmodule

`default_nettype wire

>>> hw/rtl/kdmc_channel_map.sv
// kdmc_channel_map: maps direction and duty onto the two wheel channels
// depends on kdmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module kdmc_channel_map (
  input  wire kdmc_pkg::kdmc_state_t state,
  input  wire logic             map_en,
  input  wire logic [6:0]       turn_boost,
  output kdmc_pkg::kdmc_chan_t  chan_left,
  output kdmc_pkg::kdmc_chan_t  chan_right
);
  import kdmc_pkg::*;

  logic [7:0]  d8;
  logic [7:0]  t_sum;
  logic [7:0]  t_sat;
  logic [15:0] prod;
  logic [7:0]  inner;

  always_comb begin
    d8    = {1'b0, state.duty};
    t_sum = d8 + {1'b0, turn_boost};
    t_sat = (t_sum > BOOST_CAP) ? BOOST_CAP : t_sum;
    prod  = {8'd0, t_sat} * DIV3_MUL;
    inner = {1'b0, prod[DIV3_SHIFT+6:DIV3_SHIFT]} + INNER_OFFSET;

    chan_left  = '0;
    chan_right = '0;
    if (map_en && state.duty != 7'd0) begin
      case (state.dir)
        DIR_FWD: begin
          chan_left  = '{run: 1'b1, fwd: 1'b1, duty: d8};
          chan_right = '{run: 1'b1, fwd: 1'b1, duty: d8};
        end
        DIR_BACK: begin
          chan_left  = '{run: 1'b1, fwd: 1'b0, duty: d8};
          chan_right = '{run: 1'b1, fwd: 1'b0, duty: d8};
        end
        DIR_LEFT: begin
          chan_left  = '{run: 1'b1, fwd: 1'b0, duty: d8};
          chan_right = '{run: 1'b1, fwd: 1'b1, duty: d8};
        end
        DIR_RIGHT: begin
          chan_left  = '{run: 1'b1, fwd: 1'b1, duty: d8};
          chan_right = '{run: 1'b1, fwd: 1'b0, duty: d8};
        end
        DIR_BACK_LEFT: begin
          chan_right = '{run: 1'b1, fwd: 1'b0, duty: d8};
        end
        DIR_BACK_RIGHT: begin
          chan_left  = '{run: 1'b1, fwd: 1'b0, duty: d8};
        end
        // diagonal forward turns: outer wheel boosted, inner at a third plus offset
        DIR_FWD_LEFT: begin
          chan_left  = '{run: 1'b1, fwd: 1'b1, duty: inner};
          chan_right = '{run: 1'b1, fwd: 1'b1, duty: t_sat};
        end
        DIR_FWD_RIGHT: begin
          chan_left  = '{run: 1'b1, fwd: 1'b1, duty: t_sat};
          chan_right = '{run: 1'b1, fwd: 1'b1, duty: inner};
        end
        default: begin
          chan_left  = '0;
          chan_right = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kdmc_checker.sv
// kdmc_checker: port-level assertions for the keypad motor command unit, bound to the top
// depends on kdmc_pkg and keypad_differential_motor_command_unit
`timescale 1ns / 1ps
`default_nettype none

module kdmc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_left_run,
  input wire logic                           out_left_forward,
  input wire logic [7:0]                     out_left_duty,
  input wire logic                           out_right_run,
  input wire logic                           out_right_forward,
  input wire logic [7:0]                     out_right_duty,
  input wire logic [6:0]                     out_base_now
);
  import kdmc_pkg::*;

  // a stopped channel carries no direction and no duty
  a_left_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_left_run |-> !out_left_forward && out_left_duty == 8'd0)
    else $error("left channel stopped with nonzero direction or duty");

  a_right_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_right_run |-> !out_right_forward && out_right_duty == 8'd0)
    else $error("right channel stopped with nonzero direction or duty");

  // base duty only ever comes from the letter row; both channel duties are capped at BOOST_CAP
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_base_now <= DUTY_MAX && out_left_duty <= BOOST_CAP
                  && out_right_duty <= BOOST_CAP)
    else $error("base or channel duty out of range");

  // input side only backs up while the result is held
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_duty) && $stable(out_right_duty))
    else $error("stalled result changed or dropped");

endmodule

bind keypad_differential_motor_command_unit kdmc_checker u_kdmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_left_run      (out_left_run),
  .out_left_forward  (out_left_forward),
  .out_left_duty     (out_left_duty),
  .out_right_run     (out_right_run),
  .out_right_forward (out_right_forward),
  .out_right_duty    (out_right_duty),
  .out_base_now      (out_base_now)
);

`default_nettype wire
